FILE: rtl/move_record_playback_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the move record and playback sequencer
// Define NO_ASSERTIONS to compile every check down to nothing.
// ----------------------------------------------------------------------------
`ifndef MOVE_RECORD_PLAYBACK_SEQUENCER_CORE_ASSERT_SVH
`define MOVE_RECORD_PLAYBACK_SEQUENCER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge out of reset.
`define MRPS_ASSERT_NOW(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mrps check failed: invariant");
// Antecedent at one edge implies consequent at the next edge.
`define MRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrps check failed: next-cycle rule");
`else
`define MRPS_ASSERT_NOW(label, clk, rst_n, prop)
`define MRPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrps_pkg
// Command codes, motion codes, register map and bus widths of the sequencer.
// ----------------------------------------------------------------------------
package mrps_pkg;

    // remote command codes
    localparam logic [7:0] CMD_REC_START  = 8'd11;
    localparam logic [7:0] CMD_REC_STOP   = 8'd10;
    localparam logic [7:0] CMD_PLAY_START = 8'd21;
    localparam logic [7:0] CMD_PLAY_STOP  = 8'd20;
    localparam logic [7:0] CMD_UP         = 8'd31;
    localparam logic [7:0] CMD_DOWN       = 8'd30;
    localparam logic [7:0] CMD_LEFT       = 8'd32;
    localparam logic [7:0] CMD_RIGHT      = 8'd33;

    // item kind carried in tuser
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // stored move codes: up, down, left, right
    localparam int STORE_CODE_W = 2;
    localparam logic [STORE_CODE_W-1:0] CODE_UP    = 2'd0;
    localparam logic [STORE_CODE_W-1:0] CODE_DOWN  = 2'd1;
    localparam logic [STORE_CODE_W-1:0] CODE_LEFT  = 2'd2;
    localparam logic [STORE_CODE_W-1:0] CODE_RIGHT = 2'd3;

    // motion state; a move code maps to code + 1
    localparam logic [2:0] MOT_STOP  = 3'd0;
    localparam logic [2:0] MOT_FWD   = 3'd1;
    localparam logic [2:0] MOT_BACK  = 3'd2;
    localparam logic [2:0] MOT_LEFT  = 3'd3;
    localparam logic [2:0] MOT_RIGHT = 3'd4;

    // how the second stage updates the motion
    localparam logic [1:0] MOP_KEEP  = 2'd0;
    localparam logic [1:0] MOP_STICK = 2'd1;
    localparam logic [1:0] MOP_STORE = 2'd2;
    localparam logic [1:0] MOP_STOP  = 2'd3;

    // configuration register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_TURN_OUTER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TURN_OUTER  = 3'd4;

    localparam logic [15:0] RST_MOVE_DURATION    = 16'd1000;
    localparam logic [7:0]  RST_FULL_SPEED       = 8'd255;
    localparam logic [7:0]  RST_SLOW_SPEED       = 8'd63;
    localparam logic [7:0]  RST_LEFT_TURN_OUTER  = 8'd168;
    localparam logic [7:0]  RST_RIGHT_TURN_OUTER = 8'd196;

    // stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int COUNT_OUT_W = 7;
    localparam int OUT_FIELD_W = 36;
    localparam int OUT_TDATA_W = 40;

endpackage

FILE: rtl/move_record_playback_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_record_playback_sequencer_core
// Records stick moves of a remote into a move memory and plays them back on
// the two H-bridge motor outputs, paced by one-millisecond ticks.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock on the slave stream unless stalled,
// either a tick (tuser 0) or a remote command (tuser 1), and returns exactly
// one result transfer per input on the master stream, showing drive lines,
// speeds, mode flags, store fill and playback position after that item.
// Throughput is one item per cycle while the master side takes results;
// s_axis_tready falls when both stages hold data and m_axis_tready is low.
// Stage 0 updates the modes, counters and the elapsed tick count and issues
// the move memory access (a write while recording, a read when a playback
// step is due); stage 1 picks up the memory's registered read word and
// resolves the motion and speeds into the output register. Configuration
// writes take effect at once and are meant for idle periods. The move memory
// needs no clearing after reset: playback only reads entries below the stored count.
// ----------------------------------------------------------------------------
module move_record_playback_sequencer_core #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] command_code
    input  logic [mrps_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] kind (0 tick, 1 command)
    input  logic [mrps_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // master stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] left_forward, [1] left_backward, [2] right_forward,
    // [3] right_backward, [11:4] left_speed, [19:12] right_speed,
    // [20] recording, [21] playing, [28:22] stored_moves,
    // [35:29] play_position, [39:36] zero
    output logic [mrps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [mrps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mrps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mrps_pkg::*;

    `include "move_record_playback_sequencer_core_assert.svh"

    // count holds 0..STORE_DEPTH, address holds 0..STORE_DEPTH-1
    localparam int CW  = $clog2(STORE_DEPTH + 1);
    localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CXW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    typedef struct packed {
        logic [1:0]              op;
        logic [STORE_CODE_W-1:0] code;
        logic                    rec;
        logic                    play;
        logic [CW-1:0]           total;
        logic [CW-1:0]           pidx;
    } t_stage;

    // ---------------- configuration registers ----------------
    logic [15:0] r_move_duration;
    logic [7:0]  r_full_speed;
    logic [7:0]  r_slow_speed;
    logic [7:0]  r_left_outer;
    logic [7:0]  r_right_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_duration <= RST_MOVE_DURATION;
            r_full_speed    <= RST_FULL_SPEED;
            r_slow_speed    <= RST_SLOW_SPEED;
            r_left_outer    <= RST_LEFT_TURN_OUTER;
            r_right_outer   <= RST_RIGHT_TURN_OUTER;
        end else if (i_cfg_wr_en) begin
            // indexes past the map are dropped
            unique case (i_cfg_index)
                REG_MOVE_DURATION:    r_move_duration <= i_cfg_data;
                REG_FULL_SPEED:       r_full_speed    <= i_cfg_data[7:0];
                REG_SLOW_SPEED:       r_slow_speed    <= i_cfg_data[7:0];
                REG_LEFT_TURN_OUTER:  r_left_outer    <= i_cfg_data[7:0];
                REG_RIGHT_TURN_OUTER: r_right_outer   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: mode and counter update ----------------
    logic          r_rec, r_play;
    logic [CW-1:0] r_total, r_pidx;
    logic [15:0]   r_elapsed;

    logic          n_rec, n_play;
    logic [CW-1:0] n_total, n_pidx;
    logic [15:0]   n_elapsed;
    t_stage        n_stage;

    logic                    accept;
    logic                    kind;
    logic [7:0]              cmd;
    logic                    is_stick;
    logic [STORE_CODE_W-1:0] stick_code;
    logic [15:0]             elapsed_inc;
    logic                    time_up;
    logic [CW-1:0]           pidx_inc;

    logic                    store_we;
    logic                    store_re;
    logic [STORE_CODE_W-1:0] store_rdata;

    logic                    r_s1_valid;
    t_stage                  r_s1;
    logic                    s1_adv;
    logic                    r_out_valid;

    assign accept   = s_axis_tvalid & s_axis_tready;
    assign kind     = s_axis_tuser[0];
    assign cmd      = s_axis_tdata;
    assign is_stick = (cmd == CMD_UP) || (cmd == CMD_DOWN) ||
                      (cmd == CMD_LEFT) || (cmd == CMD_RIGHT);

    always_comb begin
        priority if (cmd == CMD_UP) begin
            stick_code = CODE_UP;
        end else if (cmd == CMD_DOWN) begin
            stick_code = CODE_DOWN;
        end else if (cmd == CMD_LEFT) begin
            stick_code = CODE_LEFT;
        end else begin
            stick_code = CODE_RIGHT;
        end
    end

    // saturate the elapsed count at all ones
    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign time_up     = elapsed_inc > r_move_duration;
    assign pidx_inc    = r_pidx + CW'(1);

    always_comb begin
        n_rec     = r_rec;
        n_play    = r_play;
        n_total   = r_total;
        n_pidx    = r_pidx;
        n_elapsed = r_elapsed;
        store_we  = 1'b0;
        store_re  = 1'b0;
        n_stage.op   = MOP_KEEP;
        n_stage.code = stick_code;
        if (kind == KIND_COMMAND) begin
            // mode commands, each only from its proper mode
            priority if (cmd == CMD_REC_START && !r_rec && !r_play) begin
                n_rec   = 1'b1;
                n_total = '0;
                n_pidx  = '0;
            end else if (cmd == CMD_REC_STOP && r_rec && !r_play) begin
                n_rec = 1'b0;
            end else if (cmd == CMD_PLAY_START && !r_rec && !r_play &&
                         r_total != '0) begin
                n_play = 1'b1;
            end else if (cmd == CMD_PLAY_STOP && !r_rec && r_play) begin
                n_play = 1'b0;
            end else begin
                n_play = r_play;
            end
            // sticks drive the motors unless playing; append while recording
            if (is_stick && !n_play) begin
                if (n_rec && (n_total < DEPTH_C)) begin
                    store_we = accept;
                    n_total  = n_total + CW'(1);
                end
                n_stage.op = MOP_STICK;
                n_elapsed  = '0;
            end
        end else begin
            n_elapsed = elapsed_inc;
            if (time_up) begin
                if (r_play) begin
                    // fetch the next stored move
                    store_re   = accept;
                    n_stage.op = MOP_STORE;
                    n_elapsed  = '0;
                    if (pidx_inc >= r_total) begin
                        n_play = 1'b0;
                        n_pidx = '0;
                    end else begin
                        n_pidx = pidx_inc;
                    end
                end else begin
                    n_stage.op = MOP_STOP;
                end
            end
        end
        n_stage.rec   = n_rec;
        n_stage.play  = n_play;
        n_stage.total = n_total;
        n_stage.pidx  = n_pidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec     <= 1'b0;
            r_play    <= 1'b0;
            r_total   <= '0;
            r_pidx    <= '0;
            r_elapsed <= '0;
        end else if (accept) begin
            r_rec     <= n_rec;
            r_play    <= n_play;
            r_total   <= n_total;
            r_pidx    <= n_pidx;
            r_elapsed <= n_elapsed;
        end
    end

    // write at the fill count, read at the play position; the modes keep
    // the two from ever touching the store in the same cycle
    mrps_move_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (r_total[AW-1:0]),
        .i_wr_data (stick_code),
        .i_rd_en   (store_re),
        .i_rd_addr (r_pidx[AW-1:0]),
        .o_rd_data (store_rdata)
    );

    // ---------------- stage 1: motion resolve ----------------
    assign s1_adv        = r_s1_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_s1_valid | ~r_out_valid | m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload only; the read word waits in the memory's output register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_stage;
        end
    end

    logic [2:0] r_motion;
    logic [2:0] n_motion;

    always_comb begin
        unique case (r_s1.op)
            MOP_KEEP:  n_motion = r_motion;
            MOP_STICK: n_motion = {1'b0, r_s1.code} + 3'd1;
            MOP_STORE: n_motion = {1'b0, store_rdata} + 3'd1;
            MOP_STOP:  n_motion = MOT_STOP;
            default:   n_motion = r_motion;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion <= MOT_STOP;
        end else if (s1_adv) begin
            r_motion <= n_motion;
        end
    end

    // drive lines and speeds per motion
    logic       lf, lb, rf, rb;
    logic [7:0] ls, rs;

    always_comb begin
        lf = 1'b0;
        lb = 1'b0;
        rf = 1'b0;
        rb = 1'b0;
        ls = '0;
        rs = '0;
        unique case (n_motion)
            MOT_FWD: begin
                lf = 1'b1;
                rf = 1'b1;
                ls = r_full_speed;
                rs = r_full_speed;
            end
            MOT_BACK: begin
                lb = 1'b1;
                rb = 1'b1;
                ls = r_full_speed;
                rs = r_full_speed;
            end
            MOT_LEFT: begin
                lf = 1'b1;
                rf = 1'b1;
                ls = r_slow_speed;
                rs = r_left_outer;
            end
            MOT_RIGHT: begin
                lf = 1'b1;
                rf = 1'b1;
                ls = r_right_outer;
                rs = r_slow_speed;
            end
            default: ; // stopped: everything low
        endcase
    end

    // counts are reported in seven bits
    logic [CXW-1:0] total_x, pidx_x;
    assign total_x = CXW'(r_s1.total);
    assign pidx_x  = CXW'(r_s1.pidx);

    // ---------------- output register ----------------
    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                           pidx_x[COUNT_OUT_W-1:0], total_x[COUNT_OUT_W-1:0],
                           r_s1.play, r_s1.rec, rs, ls, rb, rf, lb, lf};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- checks ----------------
    `MRPS_ASSERT_NOW(a_mode_exclusive, i_clk, i_rst_n, !(r_rec && r_play))
    `MRPS_ASSERT_NOW(a_play_in_range, i_clk, i_rst_n, !r_play || (r_pidx < r_total))
    `MRPS_ASSERT_NOW(a_total_capped, i_clk, i_rst_n, r_total <= DEPTH_C)
    `MRPS_ASSERT_NOW(a_store_one_access, i_clk, i_rst_n, !(store_we && store_re))
    `MRPS_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid)

endmodule

FILE: rtl/mrps_move_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrps_move_store
// Single-port-write, single-port-read move memory, registered read data.
// ----------------------------------------------------------------------------
module mrps_move_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [mrps_pkg::STORE_CODE_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [mrps_pkg::STORE_CODE_W-1:0] o_rd_data
);
    import mrps_pkg::*;

    logic [STORE_CODE_W-1:0] r_mem [DEPTH];
    logic [STORE_CODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: tb/move_record_playback_sequencer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_record_playback_sequencer_core_tb
// Self-checking bench for the move record and playback sequencer. A queue of
// remote commands and millisecond ticks feeds the slave stream. An in-bench
// model of the mode rules, move store and tick timing predicts one status
// transfer per input. Each master-side transfer is checked field by field
// against the oldest prediction. Both streams stall at random.
// ----------------------------------------------------------------------------
module move_record_playback_sequencer_core_tb;
    import mrps_pkg::*;

    localparam int MOVE_SLOTS     = 64;
    localparam int PIPE_LATENCY   = 2;     // input transfer to result transfer
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer at all
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PCT       = 11;
    localparam int CALM_FROM      = 400;   // cycle window with no stalls
    localparam int CALM_TO        = 700;

    // one slave-side item
    typedef struct packed {
        logic       kind;
        logic [7:0] code;
    } t_remote_item;

    // one master-side status, packed in tdata order (lowest bit last here)
    typedef struct packed {
        logic [6:0] play_position;
        logic [6:0] stored_moves;
        logic       playing;
        logic       recording;
        logic [7:0] right_speed;
        logic [7:0] left_speed;
        logic       right_backward;
        logic       right_forward;
        logic       left_backward;
        logic       left_forward;
    } t_motor_status;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;   // [7:0] command_code
    logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;   // [0] kind
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [0] lf, [1] lb, [2] rf, [3] rb, [11:4] left_speed, [19:12] right_speed,
    // [20] recording, [21] playing, [28:22] stored_moves, [35:29] play_position
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    move_record_playback_sequencer_core #(
        .STORE_DEPTH (MOVE_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model: configuration copy and state
    // ------------------------------------------------------------------------
    logic [15:0] move_dur;
    logic [7:0]  spd_full, spd_slow, spd_left_outer, spd_right_outer;
    logic        rec_on, play_on;
    logic [1:0]  move_mem [MOVE_SLOTS];
    int          move_count, play_pos, elapsed;
    logic [2:0]  motion;

    // bench bookkeeping
    t_remote_item  pending_items [$];
    t_motor_status status_due [$];
    logic          in_taken      = 1'b0;
    int            cycle_no      = 0;
    int            quiet_cycles  = 0;
    int            errors        = 0;
    int            items_sent    = 0;
    int            results_seen  = 0;
    int            playback_steps = 0;
    int            overfull_recordings = 0;
    int            settings_loaded = 0;
    logic [7:0]    stick_codes [4] = '{CMD_UP, CMD_DOWN, CMD_LEFT, CMD_RIGHT};

    function automatic void reset_model();
        move_dur        = RST_MOVE_DURATION;
        spd_full        = RST_FULL_SPEED;
        spd_slow        = RST_SLOW_SPEED;
        spd_left_outer  = RST_LEFT_TURN_OUTER;
        spd_right_outer = RST_RIGHT_TURN_OUTER;
        rec_on     = 1'b0;
        play_on    = 1'b0;
        move_count = 0;
        play_pos   = 0;
        elapsed    = 0;
        motion     = MOT_STOP;
        foreach (move_mem[i]) move_mem[i] = CODE_UP;
    endfunction

    // Advance the model by one item and return the status it leaves behind.
    function automatic t_motor_status step_sequencer(t_remote_item it);
        t_motor_status st;
        logic [1:0]    code;
        logic          is_stick;
        st       = '0;
        is_stick = 1'b1;
        code     = CODE_UP;
        if (it.kind == KIND_COMMAND) begin
            // mode changes, each only from the proper mode
            if (it.code == CMD_REC_START && !rec_on && !play_on) begin
                rec_on     = 1'b1;
                move_count = 0;
                play_pos   = 0;
            end else if (it.code == CMD_REC_STOP && rec_on && !play_on) begin
                rec_on = 1'b0;
            end else if (it.code == CMD_PLAY_START && !rec_on && !play_on
                         && move_count > 0) begin
                play_on = 1'b1;
            end else if (it.code == CMD_PLAY_STOP && !rec_on && play_on) begin
                play_on = 1'b0;
            end
            case (it.code)
                CMD_UP:    code = CODE_UP;
                CMD_DOWN:  code = CODE_DOWN;
                CMD_LEFT:  code = CODE_LEFT;
                CMD_RIGHT: code = CODE_RIGHT;
                default:   is_stick = 1'b0;
            endcase
            // sticks drive the motors unless playback owns them
            if (is_stick && !play_on) begin
                if (rec_on && move_count < MOVE_SLOTS) begin
                    move_mem[move_count] = code;
                    move_count++;
                end
                motion  = MOT_FWD + 3'(code);
                elapsed = 0;
            end
        end else begin
            if (elapsed < 65535) elapsed++;
            if (elapsed > int'(move_dur)) begin
                if (play_on) begin
                    motion  = MOT_FWD + 3'(move_mem[play_pos]);
                    elapsed = 0;
                    play_pos++;
                    playback_steps++;
                    if (play_pos >= move_count) begin
                        play_on  = 1'b0;
                        play_pos = 0;
                    end
                end else begin
                    motion = MOT_STOP;
                end
            end
        end
        case (motion)
            MOT_FWD: begin
                st.left_forward  = 1'b1;
                st.right_forward = 1'b1;
                st.left_speed    = spd_full;
                st.right_speed   = spd_full;
            end
            MOT_BACK: begin
                st.left_backward  = 1'b1;
                st.right_backward = 1'b1;
                st.left_speed     = spd_full;
                st.right_speed    = spd_full;
            end
            MOT_LEFT: begin
                st.left_forward  = 1'b1;
                st.right_forward = 1'b1;
                st.left_speed    = spd_slow;
                st.right_speed   = spd_left_outer;
            end
            MOT_RIGHT: begin
                st.left_forward  = 1'b1;
                st.right_forward = 1'b1;
                st.left_speed    = spd_right_outer;
                st.right_speed   = spd_slow;
            end
            default: ;
        endcase
        st.recording     = rec_on;
        st.playing       = play_on;
        st.stored_moves  = 7'(move_count);
        st.play_position = 7'(play_pos);
        return st;
    endfunction

    function automatic string status_diff(t_motor_status w, t_motor_status g);
        string s = "";
        if (w.left_forward   !== g.left_forward)   s = {s, " left_forward"};
        if (w.left_backward  !== g.left_backward)  s = {s, " left_backward"};
        if (w.right_forward  !== g.right_forward)  s = {s, " right_forward"};
        if (w.right_backward !== g.right_backward) s = {s, " right_backward"};
        if (w.left_speed     !== g.left_speed)     s = {s, " left_speed"};
        if (w.right_speed    !== g.right_speed)    s = {s, " right_speed"};
        if (w.recording      !== g.recording)      s = {s, " recording"};
        if (w.playing        !== g.playing)        s = {s, " playing"};
        if (w.stored_moves   !== g.stored_moves)   s = {s, " stored_moves"};
        if (w.play_position  !== g.play_position)  s = {s, " play_position"};
        return s;
    endfunction

    function automatic string status_text(t_motor_status s);
        return $sformatf("lf%b lb%b rf%b rb%b spd %0d/%0d rec %b play %b moves %0d pos %0d",
                         s.left_forward, s.left_backward, s.right_forward,
                         s.right_backward, s.left_speed, s.right_speed, s.recording,
                         s.playing, s.stored_moves, s.play_position);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: present items and the master-side ready at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : feed
        t_remote_item nxt;
        logic         calm;
        calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_taken || !s_axis_tvalid) begin
            // advance only once the held item has been taken
            if (pending_items.size() != 0
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.kind;
                s_axis_tdata  <= nxt.code;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on each input transfer, check each result transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_motor_status got, want;
        t_remote_item  took;
        string         diff;
        cycle_no++;
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[OUT_FIELD_W-1:0];
                results_seen++;
                if (status_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("[%0t] unexpected result: %s", $realtime, status_text(got));
                end else begin
                    want = status_due.pop_front();
                    diff = status_diff(want, got);
                    if (diff != "") begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("[%0t] result %0d mismatch in%s", $realtime,
                                     results_seen, diff);
                            $display("    expected %s", status_text(want));
                            $display("    actual   %s", status_text(got));
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                took = {s_axis_tuser[0], s_axis_tdata};
                items_sent++;
                status_due.push_back(step_sequencer(took));
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(logic kind, logic [7:0] code);
        t_remote_item it;
        it.kind = kind;
        it.code = code;
        pending_items.push_back(it);
    endtask

    task automatic push_cmd(logic [7:0] code);
        push_item(KIND_COMMAND, code);
    endtask

    task automatic push_ticks(int n);
        // tdata is don't-care on a tick; keep it random
        repeat (n) push_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_noise();
        push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] any_stick();
        return stick_codes[$urandom_range(0, 3)];
    endfunction

    // Hold until every item has gone through and the pipeline is empty.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || status_due.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_MOVE_DURATION:    move_dur        = val;
            REG_FULL_SPEED:       spd_full        = val[7:0];
            REG_SLOW_SPEED:       spd_slow        = val[7:0];
            REG_LEFT_TURN_OUTER:  spd_left_outer  = val[7:0];
            REG_RIGHT_TURN_OUTER: spd_right_outer = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(logic [15:0] dur, logic [7:0] fs, logic [7:0] ss,
                                 logic [7:0] lt, logic [7:0] rt);
        write_register(REG_MOVE_DURATION,    dur);
        write_register(REG_FULL_SPEED,       {8'd0, fs});
        write_register(REG_SLOW_SPEED,       {8'd0, ss});
        write_register(REG_LEFT_TURN_OUTER,  {8'd0, lt});
        write_register(REG_RIGHT_TURN_OUTER, {8'd0, rt});
        settings_loaded++;
    endtask

    // One record-then-play session with random moves, stops and stray commands.
    // A long run fills the store and may push moves past its end.
    task automatic queue_session(int dur, bit long_run);
        int n, steps, ticks, cut;
        logic [7:0] stray [4];
        stray = '{CMD_REC_START, CMD_REC_STOP, CMD_PLAY_START, CMD_UP};
        n = long_run ? $urandom_range(64, 70) : $urandom_range(1, 6);
        if (n > MOVE_SLOTS) overfull_recordings++;
        // drop back to idle whatever noise left behind
        push_cmd(CMD_REC_STOP);
        push_cmd(CMD_PLAY_STOP);
        push_cmd(CMD_REC_START);
        for (int i = 0; i < n; i++) begin
            push_cmd(any_stick());
            if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(1, dur + 2));
            if ($urandom_range(0, 19) == 0) push_cmd(CMD_PLAY_START);
            if ($urandom_range(0, 19) == 0) push_noise();
        end
        push_cmd(CMD_REC_STOP);
        push_cmd(CMD_PLAY_START);
        // commands that playback must ignore
        if ($urandom_range(0, 1) == 0) push_cmd(any_stick());
        if ($urandom_range(0, 2) == 0) push_cmd(stray[$urandom_range(0, 3)]);
        steps = (n > MOVE_SLOTS) ? MOVE_SLOTS : n;
        ticks = steps * (dur + 1) + $urandom_range(0, dur + 2);
        if ($urandom_range(0, 3) == 0) begin
            // stop mid-way, steer by hand, then maybe resume from the kept position
            cut = $urandom_range(1, ticks - 1);
            push_ticks(cut);
            push_cmd(CMD_PLAY_STOP);
            push_cmd(any_stick());
            push_ticks($urandom_range(0, dur + 2));
            if ($urandom_range(0, 1) == 0) begin
                push_cmd(CMD_PLAY_START);
                push_ticks(ticks - cut + dur + 1);
            end
        end else begin
            push_ticks(ticks);
        end
    endtask

    task automatic queue_random_phase(int dur, int quota, bit long_first);
        if (long_first) queue_session(dur, 1'b1);
        while (pending_items.size() < quota) begin
            repeat ($urandom_range(0, 3)) push_noise();
            queue_session(dur, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : run
        int dur;
        reset_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings
        push_item(KIND_TICK, CMD_REC_START);    // a tick whatever the code says
        push_cmd(8'd0);                         // unknown codes
        push_cmd(8'd255);
        push_cmd(CMD_REC_STOP);                 // wrong mode
        push_cmd(CMD_PLAY_START);               // nothing stored yet
        push_cmd(CMD_PLAY_STOP);
        push_cmd(CMD_UP);
        push_cmd(CMD_DOWN);
        push_cmd(CMD_LEFT);
        push_cmd(CMD_RIGHT);
        push_cmd(CMD_REC_START);
        push_cmd(CMD_PLAY_START);               // refused while recording
        push_cmd(CMD_REC_START);
        push_cmd(CMD_RIGHT);
        push_cmd(CMD_LEFT);
        push_cmd(CMD_REC_STOP);
        push_cmd(CMD_PLAY_START);
        push_cmd(CMD_UP);                       // ignored during playback
        push_cmd(CMD_REC_START);
        push_cmd(CMD_PLAY_STOP);
        push_cmd(CMD_REC_START);                // empty recording
        push_cmd(CMD_REC_STOP);
        push_cmd(CMD_PLAY_START);
        push_ticks(2);
        drain();

        // random sessions under extreme and random settings; the first phase
        // opens with a recording that fills the store and may run past its size
        load_settings(16'd1, 8'd255, 8'd0, 8'd255, 8'd0);
        queue_random_phase(1, 250, 1'b1);
        drain();
        load_settings(16'd2, 8'd0, 8'd255, 8'd0, 8'd255);
        queue_random_phase(2, 100, 1'b0);
        drain();
        for (int k = 0; k < 4; k++) begin
            dur = (k < 2) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            load_settings(16'(dur), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            queue_random_phase(dur, 80, 1'b0);
            drain();
        end

        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
        $display("Run covered %0d input transfers and %0d results over %0d register settings.",
                 items_sent, results_seen, settings_loaded + 1);
        $display("It took %0d playback steps and %0d recordings past the store size.",
                 playback_steps, overfull_recordings);
        if (errors == 0 && status_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results still outstanding", errors,
                     status_due.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
